>>> hw/rtl/svr_pkg.sv
`default_nettype none

package svr_pkg;

   // Request kinds as they arrive on the request channel.
   typedef enum logic [1:0] {
      FUNC_MOVE = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_SET  = 2'd2
   } func_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_STEP_DEGREES = 2'd0,
      CSR_MIN_PULSE    = 2'd1,
      CSR_MAX_PULSE    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE_RD,
      ST_SCAN,
      ST_SCAN_RD,
      ST_SWEEP,
      ST_SWEEP_RD,
      ST_MAP,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [7:0]  step_degrees;
      logic [14:0] min_pulse_us;
      logic [14:0] max_pulse_us;
   } cfg_type;

   // Classified request as held in the queue; angles are already clamped.
   typedef struct packed {
      func_type    func;
      logic [3:0]  channel;
      logic [7:0]  target;
      logic [7:0]  start;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  out_channel;
      logic [11:0] off_count;
      logic [7:0]  angle_now;
      logic        last;
      logic        busy_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] angle;
      logic       still;
   } step_type;

   localparam logic [7:0]  ANGLE_MAX    = 8'd180;
   localparam logic [4:0]  MAX_RESULTS  = 5'd16;
   localparam int          QUEUE_DEPTH  = 4;
   localparam int          QPTR_W       = 2;
   localparam int          QCNT_W       = 3;

   // Reciprocals for the two constant divisions, both scaled by 2^24.
   localparam int          RECIP_SHIFT  = 24;
   localparam logic [18:0] RECIP_45     = 19'd372827;
   localparam logic [14:0] RECIP_625    = 15'd26843;
   localparam logic [5:0]  DIV_45       = 6'd45;
   localparam logic [9:0]  DIV_625      = 10'd625;
   localparam logic [15:0] PULSE_SAT    = 16'd20000;
   localparam logic [11:0] OFF_MAX      = 12'hFFF;

   localparam logic [7:0]  RST_STEP     = 8'd1;
   localparam logic [14:0] RST_MIN      = 15'd500;
   localparam logic [14:0] RST_MAX      = 15'd2500;

   function automatic logic [7:0] clamp_angle(input logic signed [15:0] a);
      logic [7:0] r;
      if (a < 16'sd0) begin
         r = 8'd0;
      end else if (a > $signed({8'd0, ANGLE_MAX})) begin
         r = ANGLE_MAX;
      end else begin
         r = a[7:0];
      end
      return r;
   endfunction

   // One step from pos towards goal, never past it. still is set when the
   // channel has not reached its goal after the step.
   function automatic step_type step_toward(input logic [7:0] pos,
                                            input logic [7:0] goal,
                                            input logic [7:0] s);
      step_type   r;
      logic [7:0] d;
      logic       up;
      up = goal > pos;
      d  = up ? 8'(goal - pos) : 8'(pos - goal);
      r.still = d > s;
      if (!r.still) begin
         r.angle = goal;
      end else if (up) begin
         r.angle = 8'(pos + s);
      end else begin
         r.angle = 8'(pos - s);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/svr_ram.sv
`default_nettype none

module svr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/svr_front.sv
`default_nettype none

module svr_front #(
   parameter int CHANNELS = 16
) (
   input  wire logic [1:0]         req_func,
   input  wire logic [3:0]         req_channel,
   input  wire logic signed [15:0] req_target_angle,
   input  wire logic signed [15:0] req_start_angle,
   output      logic               keep,
   output      svr_pkg::cmd_type   cmd
);

   import svr_pkg::*;

   localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

   logic in_range;

   assign in_range = {3'd0, req_channel} < CH_LIMIT;

   // Ticks always go through; moves and direct sets only for a real channel.
   always_comb begin
      cmd.func    = func_type'(req_func);
      cmd.channel = req_channel;
      cmd.target  = clamp_angle(req_target_angle);
      cmd.start   = clamp_angle(req_start_angle);
      case (req_func)
         FUNC_TICK: keep = 1'b1;
         FUNC_MOVE: keep = in_range;
         FUNC_SET:  keep = in_range;
         default:   keep = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/svr_queue.sv
`default_nettype none

module svr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire svr_pkg::cmd_type push_cmd,
   output      logic             full,
   input  wire logic             pop,
   output      logic             head_valid,
   output      svr_pkg::cmd_type head_cmd
);

   import svr_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, do_pop})
         2'b10:   count_in = QCNT_W'(count_ff + 1'b1);
         2'b01:   count_in = QCNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/svr_pwm_map.sv
`default_nettype none

module svr_pwm_map (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [7:0]       angle,
   input  wire svr_pkg::cfg_type cfg,
   output      logic             done,
   output      logic [11:0]      off_count
);

   import svr_pkg::*;

   logic [4:0]         stage_v_ff;

   // Stage 1: angle times the magnitude of the pulse span.
   logic signed [15:0] span;
   logic [14:0]        span_mag;
   logic [22:0]        s1_prod_ff;
   logic               s1_neg_ff;

   // Stage 2: quotient estimate of prod / 180, taken as (prod / 4) / 45.
   logic [20:0]        s2_v;
   logic [39:0]        s2_mul;
   logic [20:0]        s2_v_ff;
   logic [14:0]        s2_q_ff;
   logic               s2_neg_ff;

   // Stage 3: correction, signed pulse, scaling by 4096 / 32.
   logic [20:0]        s3_rem;
   logic [14:0]        s3_q;
   logic signed [17:0] s3_pulse;
   logic [15:0]        s3_pulse_pos;
   logic [22:0]        s3_v_ff;
   logic               s3_sat_ff;

   // Stage 4: quotient estimate of v / 625.
   logic [37:0]        s4_mul;
   logic [22:0]        s4_v_ff;
   logic [13:0]        s4_q_ff;
   logic               s4_sat_ff;

   // Stage 5: correction and saturation.
   logic [22:0]        s5_rem;
   logic [13:0]        s5_q;
   logic [11:0]        off_ff;

   assign span     = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
   assign span_mag = span[15] ? 15'(-span) : span[14:0];

   assign s2_v   = s1_prod_ff[22:2];
   assign s2_mul = 40'(s2_v) * 40'(RECIP_45);

   assign s3_rem = s2_v_ff - 21'(s2_q_ff * DIV_45);
   assign s3_q   = (s3_rem >= 21'(DIV_45)) ? 15'(s2_q_ff + 1'b1) : s2_q_ff;
   assign s3_pulse = $signed({3'd0, cfg.min_pulse_us})
                   + (s2_neg_ff ? -$signed({3'd0, s3_q}) : $signed({3'd0, s3_q}));
   assign s3_pulse_pos = s3_pulse[17] ? 16'd0 : s3_pulse[15:0];

   assign s4_mul = 38'(s3_v_ff) * 38'(RECIP_625);

   assign s5_rem = s4_v_ff - 23'(s4_q_ff * DIV_625);
   assign s5_q   = (s5_rem >= 23'(DIV_625)) ? 14'(s4_q_ff + 1'b1) : s4_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= {stage_v_ff[3:0], start};
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= 23'(angle * span_mag);
      s1_neg_ff  <= span[15];
      s2_v_ff    <= s2_v;
      s2_q_ff    <= s2_mul[RECIP_SHIFT+14:RECIP_SHIFT];
      s2_neg_ff  <= s1_neg_ff;
      s3_v_ff    <= {s3_pulse_pos, 7'd0};
      s3_sat_ff  <= s3_pulse_pos >= PULSE_SAT;
      s4_v_ff    <= s3_v_ff;
      s4_q_ff    <= s4_mul[RECIP_SHIFT+13:RECIP_SHIFT];
      s4_sat_ff  <= s3_sat_ff;
      off_ff     <= s4_sat_ff ? OFF_MAX : s5_q[11:0];
   end

   assign done      = stage_v_ff[4];
   assign off_count = off_ff;

endmodule

`default_nettype wire

>>> hw/rtl/svr_back.sv
`default_nettype none

module svr_back #(
   parameter int CHANNELS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire svr_pkg::cfg_type cfg,
   input  wire logic             head_valid,
   input  wire svr_pkg::cmd_type head_cmd,
   output      logic             pop,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      svr_pkg::rsp_type rsp
);

   import svr_pkg::*;

   localparam int            CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W:0] CH_END = (CH_W + 1)'(CHANNELS);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CH_W:0]       idx_ff, idx_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [4:0]          em_ff, em_in;
   logic                busy_acc_ff, busy_acc_in;
   logic [CHANNELS-1:0] known_ff, known_in;
   logic [CHANNELS-1:0] ramp_ff, ramp_in;
   logic [3:0]          out_ch_ff, out_ch_in;
   logic [7:0]          angle_ff, angle_in;
   logic                last_ff, last_in;
   logic                busy_ff, busy_in;
   logic [11:0]         off_ff, off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                go_ff, go_in;

   logic                ram_we;
   logic [CH_W-1:0]     ram_waddr;
   logic [15:0]         ram_wdata;
   logic [CH_W-1:0]     ram_raddr;
   logic [15:0]         ram_rdata;
   logic [7:0]          rd_pos;
   logic [7:0]          rd_goal;

   logic [CH_W-1:0]     head_ch;
   logic [CH_W-1:0]     cmd_ch;
   logic [CH_W-1:0]     idx_ch;
   logic [7:0]          step_eff;
   logic [7:0]          start_pos;
   step_type            stp;

   logic                map_done;
   logic [11:0]         map_off;

   // Position in the upper byte, goal in the lower byte.
   svr_ram #(
      .WIDTH (16),
      .DEPTH (CHANNELS)
   ) u_pos_goal (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   svr_pwm_map u_map (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .angle     (angle_ff),
      .cfg       (cfg),
      .done      (map_done),
      .off_count (map_off)
   );

   assign rd_pos   = ram_rdata[15:8];
   assign rd_goal  = ram_rdata[7:0];
   assign head_ch  = CH_W'(head_cmd.channel);
   assign cmd_ch   = CH_W'(cmd_ff.channel);
   assign idx_ch   = idx_ff[CH_W-1:0];
   assign step_eff = (cfg.step_degrees == 8'd0) ? 8'd1 : cfg.step_degrees;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      em_in        = em_ff;
      busy_acc_in  = busy_acc_ff;
      known_in     = known_ff;
      ramp_in      = ramp_ff;
      out_ch_in    = out_ch_ff;
      angle_in     = angle_ff;
      last_in      = last_ff;
      busy_in      = busy_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff;
      go_in        = 1'b0;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cmd_ch;
      ram_wdata    = {rd_pos, rd_goal};
      ram_raddr    = idx_ch;
      start_pos    = known_ff[cmd_ch] ? rd_pos : cmd_ff.start;
      stp          = step_toward(rd_pos, rd_goal, step_eff);

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = head_ch;
            if (head_valid) begin
               pop         = 1'b1;
               cmd_in      = head_cmd;
               idx_in      = '0;
               cnt_in      = '0;
               em_in       = '0;
               busy_acc_in = 1'b0;
               case (head_cmd.func)
                  FUNC_MOVE: begin
                     state_in = ST_MOVE_RD;
                  end
                  FUNC_SET: begin
                     ram_we            = 1'b1;
                     ram_waddr         = head_ch;
                     ram_wdata         = {head_cmd.target, head_cmd.target};
                     known_in[head_ch] = 1'b1;
                     ramp_in[head_ch]  = 1'b0;
                     busy_in           = |ramp_in;
                     out_ch_in         = head_cmd.channel;
                     angle_in          = head_cmd.target;
                     last_in           = 1'b1;
                     go_in             = 1'b1;
                     state_in          = ST_MAP;
                  end
                  FUNC_TICK: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_MOVE_RD: begin
            stp              = step_toward(start_pos, cmd_ff.target, step_eff);
            ram_we           = 1'b1;
            ram_waddr        = cmd_ch;
            ram_wdata        = {stp.angle, cmd_ff.target};
            known_in[cmd_ch] = 1'b1;
            ramp_in[cmd_ch]  = stp.still;
            busy_in          = |ramp_in;
            out_ch_in        = cmd_ff.channel;
            angle_in         = stp.angle;
            last_in          = 1'b1;
            go_in            = 1'b1;
            state_in         = ST_MAP;
         end

         // First pass of a tick: count the channels that will move and work
         // out whether any channel is still ramping once they have.
         ST_SCAN: begin
            if (idx_ff == CH_END) begin
               idx_in   = '0;
               state_in = (cnt_ff == '0) ? ST_IDLE : ST_SWEEP;
            end else if (ramp_ff[idx_ch]) begin
               if (cnt_ff < MAX_RESULTS) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  busy_acc_in = 1'b1;
                  idx_in      = (CH_W + 1)'(idx_ff + 1'b1);
               end
            end else begin
               idx_in = (CH_W + 1)'(idx_ff + 1'b1);
            end
         end

         ST_SCAN_RD: begin
            busy_acc_in = busy_acc_ff | stp.still;
            cnt_in      = 5'(cnt_ff + 1'b1);
            idx_in      = (CH_W + 1)'(idx_ff + 1'b1);
            state_in    = ST_SCAN;
         end

         // Second pass: step the same channels and report each one.
         ST_SWEEP: begin
            if (idx_ff == CH_END) begin
               state_in = ST_IDLE;
            end else if (ramp_ff[idx_ch]) begin
               state_in = ST_SWEEP_RD;
            end else begin
               idx_in = (CH_W + 1)'(idx_ff + 1'b1);
            end
         end

         ST_SWEEP_RD: begin
            ram_we           = 1'b1;
            ram_waddr        = idx_ch;
            ram_wdata        = {stp.angle, rd_goal};
            ramp_in[idx_ch]  = stp.still;
            out_ch_in        = 4'(idx_ff);
            angle_in         = stp.angle;
            last_in          = 5'(em_ff + 1'b1) == cnt_ff;
            busy_in          = busy_acc_ff;
            em_in            = 5'(em_ff + 1'b1);
            go_in            = 1'b1;
            state_in         = ST_MAP;
         end

         ST_MAP: begin
            if (map_done) begin
               off_in       = map_off;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = (CH_W + 1)'(idx_ff + 1'b1);
                  state_in = ST_SWEEP;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         known_ff     <= '0;
         ramp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         go_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         known_ff     <= known_in;
         ramp_ff      <= ramp_in;
         rsp_valid_ff <= rsp_valid_in;
         go_ff        <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      em_ff       <= em_in;
      busy_acc_ff <= busy_acc_in;
      out_ch_ff   <= out_ch_in;
      angle_ff    <= angle_in;
      last_ff     <= last_in;
      busy_ff     <= busy_in;
      off_ff      <= off_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp.out_channel = out_ch_ff;
   assign rsp.off_count   = off_ff;
   assign rsp.angle_now   = angle_ff;
   assign rsp.last        = last_ff;
   assign rsp.busy_res    = busy_ff;

endmodule

`default_nettype wire

>>> hw/rtl/servo_angle_ramp_generator_unit.sv
// A move or a direct set gives one response, its pulse mapped to a count by the five-stage
// pulse-to-count pipeline. The back end finishes one request before it pops the next; a tick
// scans every channel first, then steps and reports each ramping channel in turn. Up to four
// requests wait in the queue. Reset (synchronous, active high) clears the queue and flags, and
// sets a 1 degree step and 500 us to 2500 us.
`default_nettype none

module servo_angle_ramp_generator_unit #(
   parameter int CHANNELS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic [3:0]         req_channel,
   input  wire logic signed [15:0] req_target_angle,
   input  wire logic signed [15:0] req_start_angle,

   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [3:0]         rsp_out_channel,
   output      logic [11:0]        rsp_off_count,
   output      logic [7:0]         rsp_angle_now,
   output      logic               rsp_last,
   output      logic               rsp_busy_res,

   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_wdata
);

   import svr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic    keep;
   cmd_type front_cmd;
   logic    queue_full;
   logic    queue_push;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;
   rsp_type rsp;

   // Configuration registers. The user must write them only while the block is idle;
   // the block does not enforce this. The back end reads them directly during an operation.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_DEGREES: cfg_in.step_degrees = csr_wdata[7:0];
            CSR_MIN_PULSE:    cfg_in.min_pulse_us = csr_wdata;
            CSR_MAX_PULSE:    cfg_in.max_pulse_us = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_degrees <= RST_STEP;
         cfg_ff.min_pulse_us <= RST_MIN;
         cfg_ff.max_pulse_us <= RST_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: clamps the angles and drops requests that do nothing (the unused
   // function code, or a channel that does not exist). A dropped request is still
   // taken from the channel, it simply never enters the queue.
   svr_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_func         (req_func),
      .req_channel      (req_channel),
      .req_target_angle (req_target_angle),
      .req_start_angle  (req_start_angle),
      .keep             (keep),
      .cmd              (front_cmd)
   );

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && req_ready && keep;

   svr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back end: owns the position and goal memory and the per-channel flags,
   // sequences one request at a time and holds each response in its output
   // register until it is taken.
   svr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_out_channel = rsp.out_channel;
   assign rsp_off_count   = rsp.off_count;
   assign rsp_angle_now   = rsp.angle_now;
   assign rsp_last        = rsp.last;
   assign rsp_busy_res    = rsp.busy_res;

   // Every response of one tick reports the same busy state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> $stable(rsp_busy_res))
      else $error("busy flag changed within one tick");

   // A committed angle is always within the servo range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_now <= ANGLE_MAX))
      else $error("committed angle out of range");

   // After reset no response is pending and the queue takes requests.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

endmodule

`default_nettype wire
